[rtl/rtc_pkg.sv]
// rtc_pkg: shared types and constants for the planar RLE tile decoder.
// Used by rtc_front, rtc_queue, rtc_back and the top level.
`timescale 1ns / 1ps

package rtc_pkg;

	// Configuration register map (word index into the register file)
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_TILE_WIDTH    = 2'd0;
	localparam logic [1:0] REG_TILE_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

	// Opcodes with a 16-bit length word following
	localparam logic [7:0] OP_REPEAT_LONG  = 8'd127;
	localparam logic [7:0] OP_LITERAL_LONG = 8'd128;

	localparam logic [2:0] MAX_PLANES = 3'd4;

	// One value byte, classified by the front end
	typedef struct packed {
		logic        is_lit;  // literal byte, else repeat value
		logic        first;   // first value byte of its operation
		logic        last;    // last value byte of its operation
		logic [15:0] len;     // operation length still to go (whole length for a repeat)
		logic [7:0]  value;
	} rtc_entry_t;

endpackage

[rtl/rtc_front.sv]
// rtc_front: opcode and length parser; turns value bytes into queue entries.
// Depends on rtc_pkg.
`timescale 1ns / 1ps

module rtc_front
	import rtc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] code_byte,
	input  logic       q_full,
	output logic       push,
	output rtc_entry_t push_entry
);

	typedef enum logic [1:0] {
		PH_OPCODE,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_DATA
	} phase_t;

	phase_t      phase_q;
	logic        is_lit_q;
	logic        first_q;
	logic [7:0]  len_hi_q;
	logic [15:0] left_q;
	logic        accept;
	logic        last;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign last     = !is_lit_q || (left_q == 16'd1);
	assign push     = accept && (phase_q == PH_DATA);

	always_comb begin
		push_entry.is_lit = is_lit_q;
		push_entry.first  = first_q;
		push_entry.last   = last;
		push_entry.len    = left_q;
		push_entry.value  = code_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_OPCODE;
			is_lit_q <= 1'b0;
			first_q  <= 1'b0;
			len_hi_q <= 8'd0;
			left_q   <= 16'd0;
		end else if (accept) begin
			case (phase_q)
				PH_OPCODE: begin
					first_q <= 1'b1;
					if (code_byte < OP_LITERAL_LONG) begin
						is_lit_q <= 1'b0;
						if (code_byte == OP_REPEAT_LONG) begin
							phase_q <= PH_LEN_HI;
						end else begin
							left_q  <= 16'(code_byte) + 16'd1;
							phase_q <= PH_DATA;
						end
					end else begin
						is_lit_q <= 1'b1;
						if (code_byte == OP_LITERAL_LONG) begin
							phase_q <= PH_LEN_HI;
						end else begin
							left_q  <= 16'(9'd256 - {1'b0, code_byte});
							phase_q <= PH_DATA;
						end
					end
				end
				PH_LEN_HI: begin
					len_hi_q <= code_byte;
					phase_q  <= PH_LEN_LO;
				end
				PH_LEN_LO: begin
					left_q <= {len_hi_q, code_byte};
					// empty literal: nothing to decode, plane stays put
					if (is_lit_q && ({len_hi_q, code_byte} == 16'd0)) begin
						phase_q <= PH_OPCODE;
					end else begin
						phase_q <= PH_DATA;
					end
				end
				PH_DATA: begin
					first_q <= 1'b0;
					if (is_lit_q) begin
						left_q <= left_q - 16'd1;
					end
					if (last) begin
						phase_q <= PH_OPCODE;
						left_q  <= 16'd0;
					end
				end
				default: begin
					phase_q <= PH_OPCODE;
				end
			endcase
		end
	end

endmodule

[rtl/rtc_queue.sv]
// rtc_queue: small flop queue between the parser and the pixel back end.
// Depends on rtc_pkg for the entry type.
`timescale 1ns / 1ps

module rtc_queue
	import rtc_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  rtc_entry_t push_entry,
	output logic       full,
	input  logic       pop,
	output logic       head_valid,
	output rtc_entry_t head_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rtc_entry_t       slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (cnt_q == CNT_W'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_entry = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/rtc_back.sv]
// rtc_back: plane position tracking, clipping and result register.
// Depends on rtc_pkg; fed by rtc_queue.
`timescale 1ns / 1ps

module rtc_back
	import rtc_pkg::*;
#(
	parameter int POS_W = 13
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  rtc_entry_t       head_entry,
	output logic             pop,
	input  logic [POS_W-1:0] plane_size,
	input  logic [2:0]       channel_count,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       channel,
	output logic [11:0]      pixel_index,
	output logic [7:0]       pixel_value,
	output logic [12:0]      pixel_count,
	output logic             overrun,
	output logic             tile_done
);

	logic [POS_W-1:0] pos_q;
	logic [1:0]       chan_q;
	logic             ovr_q;

	logic             take;
	logic [POS_W-1:0] room;
	logic [15:0]      room_ext;
	logic             ovr_now;
	logic [POS_W-1:0] count;
	logic [POS_W-1:0] pos_add;
	logic             finish;
	logic             plane_full;
	logic [2:0]       planes;
	logic [2:0]       chan_inc;
	logic             done;

	assign take = !out_valid || !out_stall;
	assign pop  = head_valid && take;

	always_comb begin
		room     = (pos_q < plane_size) ? plane_size - pos_q : '0;
		room_ext = 16'(room);
		ovr_now  = head_entry.first ? (head_entry.len > room_ext) : ovr_q;
		if (head_entry.is_lit) begin
			count = (room != '0) ? POS_W'(1) : '0;
		end else begin
			count = (head_entry.len < room_ext) ? POS_W'(head_entry.len) : room;
		end
		pos_add    = pos_q + count;
		finish     = !head_entry.is_lit || head_entry.last;
		plane_full = (pos_add >= plane_size);
		if (channel_count == 3'd0) begin
			planes = 3'd1;
		end else if (channel_count > MAX_PLANES) begin
			planes = MAX_PLANES;
		end else begin
			planes = channel_count;
		end
		chan_inc = {1'b0, chan_q} + 3'd1;
		done     = finish && plane_full && (chan_inc >= planes);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			chan_q    <= 2'd0;
			ovr_q     <= 1'b0;
			out_valid <= 1'b0;
		end else if (pop) begin
			out_valid <= 1'b1;
			ovr_q     <= ovr_now;
			if (finish && plane_full) begin
				pos_q  <= '0;
				chan_q <= done ? 2'd0 : chan_inc[1:0];
			end else begin
				pos_q <= pos_add;
			end
		end else if (take) begin
			out_valid <= 1'b0;
		end
	end

	// result payload, loaded only on a transfer from the queue
	always_ff @(posedge clk) begin
		if (pop) begin
			channel     <= chan_q;
			pixel_index <= (count != '0) ? 12'(pos_q) : 12'd0;
			pixel_value <= head_entry.value;
			pixel_count <= 13'(count);
			overrun     <= ovr_now;
			tile_done   <= done;
		end
	end

endmodule

[rtl/rle_tile_channel_decoder_core.sv]
// rle_tile_channel_decoder_core: planar run-length tile decoder top level.
// Instantiates rtc_front, rtc_queue and rtc_back; depends on rtc_pkg.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  code_byte
//   output    out        out_valid/out_stall  channel, pixel_index, pixel_value,
//                                             pixel_count, overrun, tile_done
//   config    in         APB psel/penable     paddr, pwdata, prdata
//
// One compressed byte per cycle while in_stall is low. Opcode and length
// bytes finish in the parser; each value byte is held in a queue slot and
// then yields one result in the back end's result register, loaded when
// the back end pops the byte. in_stall rises only when the queue is full,
// which takes an output stall during a run of value bytes. Reset returns
// the parser to the opcode phase, empties the queue and restarts at
// plane 0, pixel 0, with a 64 x 64 x 4 tile.
`timescale 1ns / 1ps

module rle_tile_channel_decoder_core
	import rtc_pkg::*;
#(
	parameter int MAX_TILE_SIDE = 64,
	parameter int QUEUE_DEPTH   = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	// compressed stream
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        code_byte,
	// decoded writes
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        channel,
	output logic [11:0]       pixel_index,
	output logic [7:0]        pixel_value,
	output logic [12:0]       pixel_count,
	output logic              overrun,
	output logic              tile_done,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	// sides are held in 7-bit registers, so the usable side tops out at 127
	localparam int SIDE_EFF = (MAX_TILE_SIDE > 127) ? 127 : MAX_TILE_SIDE;
	localparam int SIDE_RST = (SIDE_EFF < 64) ? SIDE_EFF : 64;
	localparam int POS_W    = $clog2(SIDE_EFF * SIDE_EFF + 1);

	logic [6:0]       tile_width_q;
	logic [6:0]       tile_height_q;
	logic [2:0]       channel_count_q;
	logic [POS_W-1:0] plane_size_q;
	logic             cfg_wr;

	logic             q_push;
	rtc_entry_t       q_push_entry;
	logic             q_full;
	logic             q_pop;
	logic             q_head_valid;
	rtc_entry_t       q_head_entry;

	// Map 0 to 1 and clip at the largest side
	function automatic logic [6:0] clamp_side(input logic [6:0] v);
		logic [6:0] r;
		if (v == 7'd0) begin
			r = 7'd1;
		end else if (int'(v) > SIDE_EFF) begin
			r = 7'(SIDE_EFF);
		end else begin
			r = v;
		end
		return r;
	endfunction

	function automatic logic [POS_W-1:0] area(input logic [6:0] w, input logic [6:0] h);
		logic [13:0] p;
		p = {7'd0, clamp_side(w)} * {7'd0, clamp_side(h)};
		return POS_W'(p);
	endfunction

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	// Hold the plane size precomputed so the back end never sees a multiply;
	// it updates on the same edge as the register it follows.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q    <= 7'd64;
			tile_height_q   <= 7'd64;
			channel_count_q <= 3'd4;
			plane_size_q    <= POS_W'(SIDE_RST * SIDE_RST);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_TILE_WIDTH: begin
					tile_width_q <= pwdata[6:0];
					plane_size_q <= area(pwdata[6:0], tile_height_q);
				end
				REG_TILE_HEIGHT: begin
					tile_height_q <= pwdata[6:0];
					plane_size_q  <= area(tile_width_q, pwdata[6:0]);
				end
				REG_CHANNEL_COUNT: begin
					channel_count_q <= pwdata[2:0];
				end
				default: begin
					// drop writes outside the register map
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_TILE_WIDTH:    prdata = {25'd0, tile_width_q};
			REG_TILE_HEIGHT:   prdata = {25'd0, tile_height_q};
			REG_CHANNEL_COUNT: prdata = {29'd0, channel_count_q};
			default:           prdata = 32'd0;
		endcase
	end

	// Parse opcodes and lengths; forward value bytes
	rtc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_byte  (code_byte),
		.q_full     (q_full),
		.push       (q_push),
		.push_entry (q_push_entry)
	);

	// Decouple parsing from output stalls
	rtc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_push_entry),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head_entry (q_head_entry)
	);

	// Clip against the plane, advance position and channel, register result
	rtc_back #(
		.POS_W (POS_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (q_head_valid),
		.head_entry    (q_head_entry),
		.pop           (q_pop),
		.plane_size    (plane_size_q),
		.channel_count (channel_count_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.channel       (channel),
		.pixel_index   (pixel_index),
		.pixel_value   (pixel_value),
		.pixel_count   (pixel_count),
		.overrun       (overrun),
		.tile_done     (tile_done)
	);

endmodule
